FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Every macro takes a label, a clock, an active-low reset, a condition and a
// consequence.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (conseq)) \
		else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
		else $error("assertion failed");

`endif

FILE: src/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Codes, constants and result type of the ingress packet classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

	localparam int MAX_RESULTS = 8;

	localparam logic CMD_ADD      = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [31:0] IP_BCAST  = 32'hFFFF_FFFF;
	localparam logic [7:0]  PROTO_UDP = 8'd17;

	localparam logic [2:0] KIND_TUNNEL  = 3'd0;
	localparam logic [2:0] KIND_OTHERS  = 3'd1;
	localparam logic [2:0] KIND_BCAST   = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN = 3'd3;
	localparam logic [2:0] KIND_ADD_OK  = 3'd4;
	localparam logic [2:0] KIND_FULL    = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic       has_target;
		logic [2:0] entry_index;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

FILE: src/ipc_in_if.sv
// ----------------------------------------------------------------------------
// ipc_in_if
// Request channel: add-entry and classify transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [1:0]  link_id;
	logic [15:0] frame_type;
	logic [31:0] dst_ip;
	logic [7:0]  ip_proto;
	logic [15:0] udp_dst_port;
	logic [31:0] local_ip;
	logic [15:0] tunnel_port;

	modport source (output valid, cmd, link_id, frame_type, dst_ip, ip_proto,
		udp_dst_port, local_ip, tunnel_port, input ready);
	modport sink (input valid, cmd, link_id, frame_type, dst_ip, ip_proto,
		udp_dst_port, local_ip, tunnel_port, output ready);
endinterface

`default_nettype wire

FILE: src/ipc_out_if.sv
// ----------------------------------------------------------------------------
// ipc_out_if
// Result channel: one transaction per classification result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic       has_target;
	logic [2:0] entry_index;
	logic       last;

	modport source (output valid, kind, has_target, entry_index, last, input ready);
	modport sink (input valid, kind, has_target, entry_index, last, output ready);
endinterface

`default_nettype wire

FILE: src/ipc_ram.sv
// ----------------------------------------------------------------------------
// ipc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/ingress_packet_classifier_unit.sv
// ----------------------------------------------------------------------------
// ingress_packet_classifier_unit
// Per-link table of local IPv4 addresses and tunnel ports, with a sequenced
// destination lookup and broadcast fan-out.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and drops req.ready until
// it has handed its last result to the output register. An add, a refused
// add, a request on a link that does not exist, an empty-table broadcast and
// a lookup on an empty table emit one result from the emit state. A broadcast
// on a table of n entries emits n results (at most MAX_RESULTS), one result
// per cycle while the output is free. A unicast lookup reads the link's table
// through the single read port of the table RAM and checks one entry at a
// time (read state, then compare state) with one shared address and port
// comparator. The output register lets the next request enter while the last
// result still waits for rsp.ready; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ingress_packet_classifier_unit #(
	parameter int NUM_LINKS = 4,
	parameter int ENTRIES   = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ipc_in_if.sink    req,
	ipc_out_if.source rsp
);

	localparam int DEPTH  = NUM_LINKS * ENTRIES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EMIT  = 3'd1;
	localparam logic [2:0] S_BCAST = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic [1:0]       link_q;
	logic [31:0]      dst_q;
	logic [7:0]       proto_q;
	logic [15:0]      dport_q;
	ipc_pkg::result_t pend_q;
	ipc_pkg::result_t out_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q [NUM_LINKS];

	logic             out_free;
	logic             out_load;
	logic             accept;
	logic             link_ok;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] bcast_n;
	logic             is_bcast;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic             ram_re;
	logic [47:0]      ram_rdata;
	logic             addr_hit;
	logic             port_hit;
	logic             last_entry;

	// The output register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || rsp.ready;
	// A result is loaded into the output register in this cycle.
	assign out_load = ((state_q == S_EMIT) || (state_q == S_BCAST)) && out_free;
	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;

	assign link_ok = (32'(req.link_id) < NUM_LINKS);

	// Entry count of the requesting link.
	always_comb begin
		cur_cnt = '0;
		for (int l = 0; l < NUM_LINKS; l++) begin
			if (32'(req.link_id) == l) begin
				cur_cnt = count_q[l];
			end
		end
	end

	// Broadcast fan-out is capped at the result limit of one transaction.
	assign bcast_n = (32'(cur_cnt) > ipc_pkg::MAX_RESULTS) ?
		CNT_W'(ipc_pkg::MAX_RESULTS) : cur_cnt;

	assign is_bcast = (req.frame_type != ipc_pkg::ETH_IPV4) ||
		(req.dst_ip == ipc_pkg::IP_BCAST);

	// Table RAM: address and tunnel port of each entry side by side.
	assign ram_we = accept && link_ok && (req.cmd == ipc_pkg::CMD_ADD) &&
		(32'(cur_cnt) < ENTRIES);
	assign ram_waddr = ADDR_W'(32'(req.link_id) * ENTRIES + 32'(cur_cnt));
	assign ram_re = (state_q == S_READ);
	assign ram_raddr = ADDR_W'(32'(link_q) * ENTRIES + 32'(idx_q));

	ipc_ram #(
		.WIDTH(48),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({req.local_ip, req.tunnel_port}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared comparator used by every step of the lookup.
	assign addr_hit = (ram_rdata[47:16] == dst_q);
	assign port_hit = (proto_q == ipc_pkg::PROTO_UDP) && (ram_rdata[15:0] == dport_q);
	assign last_entry = ((idx_q + CNT_W'(1)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			link_q      <= '0;
			dst_q       <= '0;
			proto_q     <= '0;
			dport_q     <= '0;
			pend_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int l = 0; l < NUM_LINKS; l++) begin
				count_q[l] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						link_q  <= req.link_id;
						dst_q   <= req.dst_ip;
						proto_q <= req.ip_proto;
						dport_q <= req.udp_dst_port;
						idx_q   <= '0;
						state_q <= S_EMIT;
						if (!link_ok) begin
							pend_q <= '{
								kind: (req.cmd == ipc_pkg::CMD_ADD) ?
									ipc_pkg::KIND_FULL : ipc_pkg::KIND_UNKNOWN,
								has_target: 1'b0, entry_index: 3'd0, last: 1'b1};
						end else if (req.cmd == ipc_pkg::CMD_ADD) begin
							if (32'(cur_cnt) >= ENTRIES) begin
								pend_q <= '{kind: ipc_pkg::KIND_FULL, has_target: 1'b0,
									entry_index: 3'd0, last: 1'b1};
							end else begin
								for (int l = 0; l < NUM_LINKS; l++) begin
									if (32'(req.link_id) == l) begin
										count_q[l] <= cur_cnt + CNT_W'(1);
									end
								end
								pend_q <= '{kind: ipc_pkg::KIND_ADD_OK, has_target: 1'b1,
									entry_index: 3'(cur_cnt), last: 1'b1};
							end
						end else if (is_bcast) begin
							if (cur_cnt == '0) begin
								pend_q <= '{kind: ipc_pkg::KIND_BCAST, has_target: 1'b0,
									entry_index: 3'd0, last: 1'b1};
							end else begin
								n_q     <= bcast_n;
								state_q <= S_BCAST;
							end
						end else begin
							if (cur_cnt == '0) begin
								pend_q <= '{kind: ipc_pkg::KIND_UNKNOWN, has_target: 1'b0,
									entry_index: 3'd0, last: 1'b1};
							end else begin
								n_q     <= cur_cnt;
								state_q <= S_READ;
							end
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q   <= pend_q;
						state_q <= S_IDLE;
					end
				end
				S_BCAST: begin
					if (out_free) begin
						out_q <= '{kind: ipc_pkg::KIND_BCAST, has_target: 1'b1,
							entry_index: 3'(idx_q), last: last_entry};
						if (last_entry) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (addr_hit) begin
						pend_q <= '{
							kind: port_hit ? ipc_pkg::KIND_TUNNEL : ipc_pkg::KIND_OTHERS,
							has_target: 1'b1, entry_index: 3'(idx_q), last: 1'b1};
						state_q <= S_EMIT;
					end else if (last_entry) begin
						pend_q <= '{kind: ipc_pkg::KIND_UNKNOWN, has_target: 1'b0,
							entry_index: 3'd0, last: 1'b1};
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_q.kind;
	assign rsp.has_target  = out_q.has_target;
	assign rsp.entry_index = out_q.entry_index;
	assign rsp.last        = out_q.last;

endmodule

`default_nettype wire

FILE: src/ipc_checker.sv
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the ingress packet classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ipc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [2:0] rsp_kind,
	input wire logic       rsp_has_target,
	input wire logic [2:0] rsp_entry_index,
	input wire logic       rsp_last
);

	// A stalled result transaction keeps its payload.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_has_target) && $stable(rsp_entry_index) && $stable(rsp_last))

	// The block works on one request at a time.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	// A result without a target never carries an index.
	`ASSERT_SAME(a_no_target_index, clk, arst_n, rsp_valid && !rsp_has_target, rsp_entry_index == 3'd0)

	// Only a broadcast transaction yields more than one result.
	`ASSERT_SAME(a_single_result, clk, arst_n, rsp_valid && (rsp_kind != ipc_pkg::KIND_BCAST), rsp_last)

	// Tunnel, others and add-ok results always name an entry.
	`ASSERT_SAME(a_target_kinds, clk, arst_n, rsp_valid && (rsp_kind == ipc_pkg::KIND_TUNNEL || rsp_kind == ipc_pkg::KIND_OTHERS || rsp_kind == ipc_pkg::KIND_ADD_OK), rsp_has_target)

endmodule

bind ingress_packet_classifier_unit ipc_checker u_ipc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_has_target (rsp.has_target),
	.rsp_entry_index(rsp.entry_index),
	.rsp_last       (rsp.last)
);

`default_nettype wire
